// ===== hdl/lava_texture_animator_macros.svh =====
// Assertion macros for the lava tile animator.
// Used by the top level; empty bodies when SYNTHESIS is defined.
`ifndef LAVA_TEXTURE_ANIMATOR_MACROS_SVH
`define LAVA_TEXTURE_ANIMATOR_MACROS_SVH
`ifndef SYNTHESIS
`define LTA_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lta check");
`define LTA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lta check");
`else
`define LTA_ASSERT_IMPL(label, clk, rst, a, c)
`define LTA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/lta_pkg.sv =====
// Package for the lava tile animator: default sizes and the register map.
// No dependencies.
package lta_pkg;
  localparam int SIDE_DEF = 16;
  localparam int FRAC_DEF = 16;
  localparam logic [1:0] REG_ANAGLYPH = 2'd0;
endpackage

// ===== hdl/lta_ramp.sv =====
// Colour ramp for one flame value, worked over several cycles with one multiplier for its ramp steps.
// Depends on lta_pkg.
module lta_ramp #(
  parameter int FRAC_BITS = lta_pkg::FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [FRAC_BITS+3:0] flame,
  input  logic anaglyph,
  output logic done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import lta_pkg::*;
  localparam int VW = FRAC_BITS + 1;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;
  // Reciprocal of a hundred with 22 fraction bits; exact for sums below 2^15.
  localparam logic [15:0] INV100 = 16'd41944;
  typedef enum logic [2:0] {R_IDLE, R_SQ, R_RED, R_GRN, R_Q4, R_BLU, R_MIX} rstate_t;
  rstate_t st;
  logic [VW-1:0] v, sq, q4;
  logic [VW-1:0] ma;
  logic [VW-1:0] mb;
  logic [2*VW-1:0] prod;
  logic [7:0] r, g, b;
  logic [14:0] wr, wg, wb;
  logic [30:0] pr, pg, pb;
  logic [7:0] nr, ng, nb;
  logic signed [FRAC_BITS+4:0] f2;

  assign f2 = {flame, 1'b0};
  assign prod = ma * mb;

  // Multiplier operand selection per step.
  always_comb begin
    ma = v;
    mb = v;
    case (st)
      R_SQ:  begin ma = v;  mb = v; end
      R_RED: begin ma = v;  mb = VW'(100); end
      R_GRN: begin ma = sq; mb = VW'(255); end
      R_Q4:  begin ma = sq; mb = sq; end
      R_BLU: begin ma = q4; mb = VW'(128); end
      default: begin ma = v; mb = v; end
    endcase
  end

  // Anaglyph weights; quotients by a hundred through a reciprocal multiply.
  always_comb begin
    wr = 15'(r) * 15'd30 + 15'(g) * 15'd59 + 15'(b) * 15'd11;
    wg = 15'(r) * 15'd30 + 15'(g) * 15'd70;
    wb = 15'(r) * 15'd30 + 15'(b) * 15'd70;
    pr = {16'b0, wr} * {15'b0, INV100};
    pg = {16'b0, wg} * {15'b0, INV100};
    pb = {16'b0, wb} * {15'b0, INV100};
    nr = pr[29:22];
    ng = pg[29:22];
    nb = pb[29:22];
  end

  // Sequencer and registers.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st <= R_IDLE;
    end else begin
      case (st)
        R_IDLE: if (start) begin
          if (f2 < 0) v <= '0;
          else if (f2 > $signed({4'b0, ONE})) v <= ONE;
          else v <= VW'(f2);
          st <= R_SQ;
        end
        R_SQ:  begin sq <= VW'(prod >> FRAC_BITS); st <= R_RED; end
        R_RED: begin r <= 8'(155 + (prod >> FRAC_BITS)); st <= R_GRN; end
        R_GRN: begin g <= 8'(prod >> FRAC_BITS); st <= R_Q4; end
        R_Q4:  begin q4 <= VW'(prod >> FRAC_BITS); st <= R_BLU; end
        R_BLU: begin b <= 8'(prod >> FRAC_BITS); st <= R_MIX; end
        R_MIX: begin
          red   <= anaglyph ? nr : r;
          green <= anaglyph ? ng : g;
          blue  <= anaglyph ? nb : b;
          done  <= 1'b1;
          st    <= R_IDLE;
        end
        default: st <= R_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/lava_texture_animator.sv =====
// Lava tile animator. One cell per input beat, one RGB pixel beat per cell.
// After reset a clearing pass zeroes the flame banks, heat and fuel. Each cell
// then runs through thirteen reads, each a read state and an accumulate state,
// nine from the flame bank and four from heat; the divisions by ten and by a
// hundred in S_DIV, S_FDIV and S_HEAT on one shared reciprocal multiplier; the
// write of the stores in S_WR; the colour ramp in lta_ramp, its steps on one
// multiplier; the pixel beat in S_OUT, held while out_stall is high; and the
// return to S_IDLE. A new input beat is taken only once the last pixel is taken.
// SIDE must be a power of two. in_stall is high while clearing, while a cell is
// at work or while its pixel waits.
module lava_texture_animator #(
  parameter int SIDE = lta_pkg::SIDE_DEF,
  parameter int FRAC_BITS = lta_pkg::FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic spark,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] cell_index,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic last_of_frame
);
  import lta_pkg::*;
  `include "lava_texture_animator_macros.svh"
  localparam int CELLS = SIDE * SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int SW = $clog2(SIDE);
  localparam int W = FRAC_BITS + 4;
  localparam int AccW = W + 5;
  localparam longint ONEL = 64'sd1 << FRAC_BITS;
  localparam logic signed [W-1:0] QMAX = W'(8 * ONEL - 1);
  localparam logic signed [W-1:0] QMIN = W'(-8 * ONEL);
  localparam logic signed [W-1:0] FDEC = W'((6 * ONEL + 50) / 100);
  localparam logic signed [W-1:0] FSPK = W'(3 * ONEL / 2);
  // Reciprocals of ten and a hundred, exact for magnitudes below 2^AccW and 2^W.
  localparam int K10 = AccW + 4;
  localparam int K100 = W + 7;
  localparam logic [AccW:0] M10 = (AccW+1)'(((64'sd1 << K10) + 9) / 10);
  localparam logic [AccW:0] M100 = (AccW+1)'(((64'sd1 << K100) + 99) / 100);

  typedef enum logic [3:0] {S_CLR, S_IDLE, S_RD, S_ACC, S_DIV, S_FDIV, S_HEAT, S_WR,
                            S_RAMP, S_OUT} state_t;
  state_t st;

  logic anaglyph;
  logic [AW-1:0] ctr;
  logic bank;
  logic spk;

  // Stores: flame banks, heat and fuel, one write and one read port each, registered read.
  logic signed [W-1:0] fmem [2*CELLS];
  logic signed [W-1:0] hmem [CELLS];
  logic signed [W-1:0] umem [CELLS];
  logic signed [W-1:0] frd, hrd, urd;
  logic [AW:0] faddr;
  logic [AW-1:0] haddr;
  logic fwe, hwe, uwe;
  logic signed [W-1:0] fwd, hwd, uwd;
  logic [AW:0] clr;

  // Sequencer registers.
  logic [3:0] step;
  logic signed [AccW-1:0] acc;
  logic signed [W-1:0] hcur, fcur, nflame, nheat;
  logic [AccW-1:0] mag;
  logic neg;
  logic rstart, rdone;

  // Shared multiplier signals.
  logic [AccW:0] mulb;
  logic [2*AccW:0] mprod;
  logic [W:0] quot;
  logic signed [W+1:0] qsig, hsum;

  logic [SW-1:0] x, y, xa, ya;
  logic signed [1:0] ox, oy;
  logic signed [1:0] ddx, ddy;

  assign x = ctr[AW-1:SW];
  assign y = ctr[SW-1:0];

  function automatic logic signed [1:0] wob(input logic [SW-1:0] i);
    longint n;
    n = 1000000 * longint'(i);
    if (n > 156785 * SIDE && n < 343215 * SIDE) return 2'sd1;
    if (n > 656785 * SIDE && n < 843215 * SIDE) return -2'sd1;
    return 2'sd0;
  endfunction

  assign ox = wob(y);
  assign oy = wob(x);

  // Address of read step: nine flame reads, then four heat reads, then fuel.
  always_comb begin
    case (step)
      4'd0, 4'd1, 4'd2: ddx = -2'sd1;
      4'd3, 4'd4, 4'd5: ddx = 2'sd0;
      default: ddx = 2'sd1;
    endcase
    case (step)
      4'd0, 4'd3, 4'd6: ddy = -2'sd1;
      4'd1, 4'd4, 4'd7: ddy = 2'sd0;
      default: ddy = 2'sd1;
    endcase
    xa = x + SW'(ddx) + SW'(ox);
    ya = y + SW'(ddy) + SW'(oy);
    faddr = {bank, ya, xa};
    case (step)
      4'd9:  haddr = AW'(x) + (AW'(y) << SW);
      4'd10: haddr = AW'(SW'(x + 1'b1)) + (AW'(y) << SW);
      4'd11: haddr = AW'(SW'(x + 1'b1)) + (AW'(SW'(y + 1'b1)) << SW);
      4'd12: haddr = AW'(x) + (AW'(SW'(y + 1'b1)) << SW);
      default: haddr = AW'(x) + (AW'(y) << SW);
    endcase
  end

  logic [AW-1:0] here;
  assign here = AW'(x) + (AW'(y) << SW);

  always_ff @(posedge clk) begin
    if (fwe) fmem[st == S_CLR ? clr[AW:0] : {~bank, here}] <= fwd;
    frd <= fmem[faddr];
    if (hwe) hmem[st == S_CLR ? clr[AW-1:0] : here] <= hwd;
    hrd <= hmem[haddr];
    if (uwe) umem[st == S_CLR ? clr[AW-1:0] : here] <= uwd;
    urd <= umem[here];
  end

  always_comb begin
    fwe = 1'b0; hwe = 1'b0; uwe = 1'b0;
    fwd = '0; hwd = '0; uwd = '0;
    if (st == S_CLR) begin
      fwe = 1'b1;
      hwe = !clr[AW];
      uwe = !clr[AW];
    end else if (st == S_WR) begin
      fwe = 1'b1; fwd = nflame;
      hwe = 1'b1; hwd = nheat;
      uwe = 1'b1;
      if (spk) uwd = FSPK;
      else if (fcur - FDEC < fcur) uwd = fcur - FDEC;
      else uwd = QMIN;
    end
  end

  // Shared reciprocal multiplier for the divisions by ten and by a hundred.
  always_comb begin
    mulb = (st == S_HEAT) ? M100 : M10;
    mprod = {{(AccW+1){1'b0}}, mag} * {{AccW{1'b0}}, mulb};
    quot = (st == S_HEAT) ? mprod[K100 +: W+1] : mprod[K10 +: W+1];
    qsig = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    hsum = qsig + (W+2)'(hcur);
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {31'b0, anaglyph};

  lta_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
    .clk(clk), .rst(rst), .start(rstart), .flame(nflame), .anaglyph(anaglyph),
    .done(rdone), .red(red), .green(green), .blue(blue)
  );

  assign in_stall = (st != S_IDLE);

  // Main sequencer: clear, accumulate, divide by ten and a hundred, write, colour, output.
  always_ff @(posedge clk) begin
    rstart <= 1'b0;
    if (rst) begin
      st <= S_CLR; clr <= '0; ctr <= '0; bank <= 1'b0; anaglyph <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_ANAGLYPH) anaglyph <= pwdata[0];
      case (st)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(2*CELLS-1)) st <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          spk <= spark; step <= '0; acc <= '0; st <= S_RD;
        end
        S_RD: begin step <= step + 1'b1; st <= S_ACC; end
        S_ACC: begin
          if (step <= 4'd9) acc <= acc + AccW'(frd);
          else begin
            acc <= acc + AccW'(hrd) + AccW'(hrd);
            if (step == 4'd10) hcur <= hrd;
          end
          if (step == 4'd13) begin
            fcur <= urd;
            st <= S_DIV;
          end else st <= S_RD;
        end
        S_DIV: begin
          mag <= (acc < 0 ? AccW'(-acc) : AccW'(acc)) + AccW'(5);
          neg <= acc < 0;
          st <= S_FDIV;
        end
        S_FDIV: begin
          if (qsig > QMAX) nflame <= QMAX;
          else if (qsig < QMIN) nflame <= QMIN;
          else nflame <= W'(qsig);
          mag <= (fcur < 0 ? -(AccW'(fcur)) : AccW'(fcur)) + AccW'(50);
          neg <= fcur < 0;
          st <= S_HEAT;
        end
        S_HEAT: begin
          if (hsum > QMAX) nheat <= QMAX;
          else if (hsum < 0) nheat <= '0;
          else nheat <= W'(hsum);
          st <= S_WR;
        end
        S_WR: begin rstart <= 1'b1; st <= S_RAMP; end
        S_RAMP: if (rdone) begin
          out_valid <= 1'b1;
          cell_index <= 8'(AW'(x) + (AW'(y) << SW));
          last_of_frame <= (ctr == AW'(CELLS-1));
          ctr <= ctr + 1'b1;
          if (ctr == AW'(CELLS-1)) bank <= ~bank;
          st <= S_OUT;
        end
        S_OUT: if (!out_stall) begin out_valid <= 1'b0; st <= S_IDLE; end
        default: st <= S_IDLE;
      endcase
    end
  end

  `LTA_ASSERT_IMPL(a_no_take_busy, clk, rst, out_valid, in_stall)
  `LTA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `LTA_ASSERT_IMPL(a_last_wrap, clk, rst, out_valid && last_of_frame, ctr == '0)
endmodule
